// File: rtl/core/arlr_pkg.sv
// ----------------------------------------------------------------------------
// arlr_pkg: shared types and constants of the line and rectangle rasterizer
// Frame store geometry, command codes and the queued command record.
// ----------------------------------------------------------------------------
package arlr_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int LIM_W      = 7;
	localparam int CW         = 14;
	localparam int ERR_W      = 15;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [2:0] MODE_PLOT    = 3'd0;
	localparam logic [2:0] MODE_LINE    = 3'd1;
	localparam logic [2:0] MODE_OUTLINE = 3'd2;
	localparam logic [2:0] MODE_FILL    = 3'd3;
	localparam logic [2:0] MODE_READ    = 3'd4;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [ERR_W-1:0] err_t;

	typedef enum logic [2:0] {
		K_NOP     = 3'd0,
		K_LINE    = 3'd1,
		K_OUTLINE = 3'd2,
		K_FILL    = 3'd3,
		K_READ    = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		coord_t      xa;
		coord_t      ya;
		coord_t      xb;
		coord_t      yb;
		logic [11:0] dx;
		logic [11:0] dy;
		logic        sx_neg;
		logic        sy_neg;
		logic [3:0]  pen_lo;
		logic [3:0]  pen_hi;
		logic [31:0] color;
	} cmd_t;

	function automatic coord_t sext12(input logic [11:0] v);
		sext12 = {{(CW-12){v[11]}}, v};
	endfunction

endpackage

// File: rtl/core/arlr_if.sv
// ----------------------------------------------------------------------------
// arlr_if: command and result channels of the rasterizer
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface arlr_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [11:0] x_start;
	logic signed [11:0] y_start;
	logic signed [11:0] x_end;
	logic signed [11:0] y_end;
	logic [31:0]        color;
	logic [3:0]         pen_weight;

	modport source (output valid, mode, x_start, y_start, x_end, y_end, color, pen_weight,
		input ready);
	modport sink (input valid, mode, x_start, y_start, x_end, y_end, color, pen_weight,
		output ready);
endinterface

interface arlr_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_color;
	logic        done_res;

	modport source (output valid, read_color, done_res, input ready);
	modport sink (input valid, read_color, done_res, output ready);
endinterface

// File: rtl/core/alpha_blend_line_rect_rasterizer_top.sv
// ----------------------------------------------------------------------------
// alpha_blend_line_rect_rasterizer_top: 2D drawing engine with alpha blend
// Plots pixels, pen lines and rectangles into a 64 x 64 ARGB frame store.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as words on the cmd channel (valid/ready). Each
// command produces exactly one result word on the res channel: read_color
// carries the pixel for a read command and zero otherwise, and done_res is
// always one. The APB port sets the clipping width (offset 0) and height
// (offset 4); write them only while no command is in flight.
// Pacing. Each pixel that lands inside the buffer takes a frame store read
// (S_RD) and then a blend and write (S_WR); each pen square or rectangle
// side also passes S_BOX and S_NEXT, and each command S_IDLE and S_DONE
// (a read also S_RDWAIT). The blend needs the old pixel, so each write
// waits for the read of its own pixel; this sets the pace.
// Reset. After arst_n is released the frame store is cleared by a pass over
// all 4096 addresses; cmd.ready stays low during that pass, the APB port works.
// Stalls. A two-word queue decouples intake from drawing, and the result
// register holds a finished word while the receiver keeps ready low; the
// back end then waits at the end of its next command.
// ----------------------------------------------------------------------------
module alpha_blend_line_rect_rasterizer_top (
	input  logic        clk,
	input  logic        arst_n,
	arlr_cmd_if.sink    cmd,
	arlr_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [arlr_pkg::LIM_W-1:0] width_q, height_q, lim_w, lim_h;
	arlr_pkg::cmd_t             head;
	logic                       head_valid, pop, clearing, cfg_wr;

	// Configuration registers: offset bit 2 picks the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == arlr_pkg::REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= arlr_pkg::LIM_W'(arlr_pkg::MAX_WIDTH);
			height_q <= arlr_pkg::LIM_W'(arlr_pkg::MAX_HEIGHT);
		end else if (cfg_wr) begin
			if (paddr[2] == arlr_pkg::REG_WIDTH) width_q <= pwdata[arlr_pkg::LIM_W-1:0];
			else height_q <= pwdata[arlr_pkg::LIM_W-1:0];
		end
	end

	// Sizes above the store clip as the store size itself.
	assign lim_w = (width_q > arlr_pkg::LIM_W'(arlr_pkg::MAX_WIDTH))
		? arlr_pkg::LIM_W'(arlr_pkg::MAX_WIDTH) : width_q;
	assign lim_h = (height_q > arlr_pkg::LIM_W'(arlr_pkg::MAX_HEIGHT))
		? arlr_pkg::LIM_W'(arlr_pkg::MAX_HEIGHT) : height_q;

	arlr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.clearing   (clearing),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	arlr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.lim_w      (lim_w),
		.lim_h      (lim_h),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.clearing   (clearing),
		.res        (res)
	);

endmodule

// File: rtl/core/arlr_front.sv
// ----------------------------------------------------------------------------
// arlr_front: command intake, classification and command queue
// Turns each command word into a drawing job and holds it for the back end.
// ----------------------------------------------------------------------------
module arlr_front (
	input  logic                clk,
	input  logic                arst_n,
	arlr_cmd_if.sink            cmd,
	input  logic                clearing,
	input  logic                pop,
	output arlr_pkg::cmd_t      head,
	output logic                head_valid
);

	arlr_pkg::cmd_t                  job;
	arlr_pkg::coord_t                xs, ys, xe, ye, ddx, ddy;
	arlr_pkg::cmd_t                  fifo_q [arlr_pkg::QDEPTH];
	logic [arlr_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [arlr_pkg::QPTR_W:0]       count_q;
	logic                            push;

	assign cmd.ready  = !clearing && (count_q < (arlr_pkg::QPTR_W+1)'(arlr_pkg::QDEPTH));
	assign push       = cmd.valid && cmd.ready;
	assign head       = fifo_q[rd_q];
	assign head_valid = (count_q != '0);

	always_comb begin
		xs  = arlr_pkg::sext12(cmd.x_start);
		ys  = arlr_pkg::sext12(cmd.y_start);
		xe  = arlr_pkg::sext12(cmd.x_end);
		ye  = arlr_pkg::sext12(cmd.y_end);
		ddx = xe - xs;
		ddy = ye - ys;
		job        = '0;
		job.color  = cmd.color;
		job.xa     = xs;
		job.ya     = ys;
		job.xb     = xs;
		job.yb     = ys;
		unique case (cmd.mode)
			arlr_pkg::MODE_PLOT: begin
				job.kind = arlr_pkg::K_LINE;
			end
			arlr_pkg::MODE_LINE: begin
				job.kind   = arlr_pkg::K_LINE;
				job.xb     = xe;
				job.yb     = ye;
				if (ddx < 0) job.dx = 12'(-ddx);
				else job.dx = 12'(ddx);
				if (ddy < 0) job.dy = 12'(-ddy);
				else job.dy = 12'(ddy);
				job.sx_neg = !(xs < xe);
				job.sy_neg = !(ys < ye);
				job.pen_lo = {1'b0, cmd.pen_weight[3:1]};
				job.pen_hi = 4'((5'(cmd.pen_weight) + 5'd1) >> 1);
			end
			arlr_pkg::MODE_OUTLINE, arlr_pkg::MODE_FILL: begin
				job.kind = (cmd.mode == arlr_pkg::MODE_FILL) ? arlr_pkg::K_FILL
					: arlr_pkg::K_OUTLINE;
				job.xa = (xs < xe) ? xs : xe;
				job.xb = (xs < xe) ? xe : xs;
				job.ya = (ys < ye) ? ys : ye;
				job.yb = (ys < ye) ? ye : ys;
			end
			arlr_pkg::MODE_READ: begin
				job.kind = arlr_pkg::K_READ;
			end
			default: begin
				job.kind = arlr_pkg::K_NOP;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/core/arlr_back.sv
// ----------------------------------------------------------------------------
// arlr_back: pixel sequencer, blender and frame store
// Walks each job as clipped boxes of pixels with a read, blend and write each.
// ----------------------------------------------------------------------------
module arlr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [arlr_pkg::LIM_W-1:0]    lim_w,
	input  logic [arlr_pkg::LIM_W-1:0]    lim_h,
	input  arlr_pkg::cmd_t                head,
	input  logic                          head_valid,
	output logic                          pop,
	output logic                          clearing,
	arlr_res_if.source                    res
);

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_BOX    = 8'b0000_0100,
		S_RD     = 8'b0000_1000,
		S_WR     = 8'b0001_0000,
		S_NEXT   = 8'b0010_0000,
		S_RDWAIT = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	arlr_pkg::cmd_t                  cmd_q;
	arlr_pkg::coord_t                cx_q, cy_q;
	arlr_pkg::err_t                  err_q;
	logic [1:0]                      phase_q;
	logic [arlr_pkg::X_W-1:0]        px_q, bx0_q, bx1_q;
	logic [arlr_pkg::Y_W-1:0]        py_q, by1_q;
	logic [arlr_pkg::ADDR_W-1:0]     clr_q;
	logic [31:0]                     rdcol_q, res_color_q, rdata_q;
	logic                            res_valid_q;
	logic [31:0]                     mem [arlr_pkg::DEPTH];

	arlr_pkg::coord_t                rx0, rx1, ry0, ry1, kx0, kx1, ky0, ky1, wmax, hmax;
	logic                            box_empty, head_inside, res_free;
	logic [arlr_pkg::ADDR_W-1:0]     pix_addr, raddr, waddr;
	logic                            we;
	logic [31:0]                     blended, wdata;
	logic signed [arlr_pkg::ERR_W:0] e2;
	logic                            step_x, step_y;

	assign clearing       = (state_q == S_CLEAR);
	assign res.valid      = res_valid_q;
	assign res.read_color = res_color_q;
	assign res.done_res   = 1'b1;
	assign res_free       = !res_valid_q || res.ready;
	assign pop            = (state_q == S_IDLE) && head_valid;

	assign wmax = arlr_pkg::coord_t'(lim_w) - arlr_pkg::coord_t'(1);
	assign hmax = arlr_pkg::coord_t'(lim_h) - arlr_pkg::coord_t'(1);

	// Raw box of the current pass, then clipped to the buffer in use.
	always_comb begin
		rx0 = cmd_q.xa;
		rx1 = cmd_q.xb;
		ry0 = cmd_q.ya;
		ry1 = cmd_q.yb;
		unique case (cmd_q.kind)
			arlr_pkg::K_LINE: begin
				rx0 = cx_q - arlr_pkg::coord_t'(cmd_q.pen_lo);
				rx1 = cx_q + arlr_pkg::coord_t'(cmd_q.pen_hi);
				ry0 = cy_q - arlr_pkg::coord_t'(cmd_q.pen_lo);
				ry1 = cy_q + arlr_pkg::coord_t'(cmd_q.pen_hi);
			end
			arlr_pkg::K_OUTLINE: begin
				unique case (phase_q)
					2'd0: rx1 = cmd_q.xa;
					2'd1: rx0 = cmd_q.xb;
					2'd2: ry1 = cmd_q.ya;
					default: ry0 = cmd_q.yb;
				endcase
			end
			default: begin
			end
		endcase
		kx0 = (rx0 < 0) ? '0 : rx0;
		kx1 = (rx1 > wmax) ? wmax : rx1;
		ky0 = (ry0 < 0) ? '0 : ry0;
		ky1 = (ry1 > hmax) ? hmax : ry1;
		box_empty = (kx0 > kx1) || (ky0 > ky1);
	end

	assign head_inside = (head.xa >= 0) && (head.ya >= 0)
		&& (head.xa < arlr_pkg::coord_t'(lim_w)) && (head.ya < arlr_pkg::coord_t'(lim_h));

	assign pix_addr = arlr_pkg::ADDR_W'(arlr_pkg::ADDR_W'(py_q) * arlr_pkg::ADDR_W'(arlr_pkg::MAX_WIDTH)
		+ arlr_pkg::ADDR_W'(px_q));
	assign raddr = (state_q == S_IDLE)
		? arlr_pkg::ADDR_W'(arlr_pkg::ADDR_W'(head.ya[arlr_pkg::Y_W-1:0])
			* arlr_pkg::ADDR_W'(arlr_pkg::MAX_WIDTH) + arlr_pkg::ADDR_W'(head.xa[arlr_pkg::X_W-1:0]))
		: pix_addr;
	assign we    = (state_q == S_WR) || (state_q == S_CLEAR);
	assign waddr = clearing ? clr_q : pix_addr;
	assign wdata = clearing ? '0 : blended;

	// Per channel: (old*(255-a) + new*a) / 255, the division done as
	// (s + (s >> 8) + 1) >> 8, which is exact for every sum that can occur.
	always_comb begin
		logic [7:0]  a, o, n;
		logic [15:0] s;
		logic [16:0] q;
		a = cmd_q.color[31:24];
		blended = '0;
		for (int ch = 0; ch < 4; ch++) begin
			o = rdata_q[ch*8 +: 8];
			n = cmd_q.color[ch*8 +: 8];
			s = 16'(o * (8'd255 - a)) + 16'(n * a);
			q = (17'(s) + 17'(s[15:8]) + 17'd1) >> 8;
			blended[ch*8 +: 8] = q[7:0];
		end
	end

	// Bresenham step of the line centre.
	always_comb begin
		e2     = {err_q, 1'b0};
		step_x = e2 > -(arlr_pkg::ERR_W+1)'(signed'({1'b0, cmd_q.dy}));
		step_y = e2 < (arlr_pkg::ERR_W+1)'(signed'({1'b0, cmd_q.dx}));
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q   <= head;
				cx_q    <= head.xa;
				cy_q    <= head.ya;
				err_q   <= arlr_pkg::err_t'({1'b0, head.dx}) - arlr_pkg::err_t'({1'b0, head.dy});
				phase_q <= '0;
				rdcol_q <= '0;
			end
			S_BOX: begin
				px_q  <= kx0[arlr_pkg::X_W-1:0];
				bx0_q <= kx0[arlr_pkg::X_W-1:0];
				bx1_q <= kx1[arlr_pkg::X_W-1:0];
				py_q  <= ky0[arlr_pkg::Y_W-1:0];
				by1_q <= ky1[arlr_pkg::Y_W-1:0];
			end
			S_WR: begin
				if (px_q == bx1_q) begin
					px_q <= bx0_q;
					py_q <= py_q + 1'b1;
				end else begin
					px_q <= px_q + 1'b1;
				end
			end
			S_NEXT: begin
				phase_q <= phase_q + 1'b1;
				err_q   <= err_q - (step_x ? arlr_pkg::err_t'({1'b0, cmd_q.dy}) : '0)
					+ (step_y ? arlr_pkg::err_t'({1'b0, cmd_q.dx}) : '0);
				if (step_x) cx_q <= cmd_q.sx_neg ? cx_q - 1'b1 : cx_q + 1'b1;
				if (step_y) cy_q <= cmd_q.sy_neg ? cy_q - 1'b1 : cy_q + 1'b1;
			end
			S_RDWAIT: begin
				rdcol_q <= rdata_q;
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && res_free) res_color_q <= rdcol_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && res_free) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == arlr_pkg::ADDR_W'(arlr_pkg::DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (head_valid) begin
						priority case (head.kind)
							arlr_pkg::K_LINE, arlr_pkg::K_OUTLINE, arlr_pkg::K_FILL:
								state_q <= S_BOX;
							arlr_pkg::K_READ:
								state_q <= head_inside ? S_RDWAIT : S_DONE;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_BOX: state_q <= box_empty ? S_NEXT : S_RD;
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (px_q == bx1_q && py_q == by1_q) state_q <= S_NEXT;
					else state_q <= S_RD;
				end
				S_NEXT: begin
					priority case (cmd_q.kind)
						arlr_pkg::K_LINE:
							state_q <= (cx_q == cmd_q.xb && cy_q == cmd_q.yb) ? S_DONE : S_BOX;
						arlr_pkg::K_OUTLINE:
							state_q <= (phase_q == 2'd3) ? S_DONE : S_BOX;
						default: state_q <= S_DONE;
					endcase
				end
				S_RDWAIT: state_q <= S_DONE;
				S_DONE: begin
					if (res_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: tb/arlr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arlr_checker: frame store predictor and result scoreboard
// Mirrors the drawing engine's frame store from the accepted command words
// and the APB size writes, and compares each result word against the oldest
// expected one.
// ----------------------------------------------------------------------------
module arlr_checker (
	input  logic        clk,
	input  logic        arst_n,
	arlr_cmd_if         cmd,
	arlr_res_if         res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          outstanding
);

	typedef struct {
		logic [31:0] read_color;
		logic        done_res;
	} result_t;

	logic [31:0]  pixels [arlr_pkg::DEPTH];
	logic [6:0]   clip_w;
	logic [6:0]   clip_h;
	result_t      pending_q [$];

	function automatic int lim_x();
		return (clip_w > arlr_pkg::MAX_WIDTH) ? arlr_pkg::MAX_WIDTH : int'(clip_w);
	endfunction

	function automatic int lim_y();
		return (clip_h > arlr_pkg::MAX_HEIGHT) ? arlr_pkg::MAX_HEIGHT : int'(clip_h);
	endfunction

	function automatic bit on_buffer(int x, int y);
		return x >= 0 && y >= 0 && x < lim_x() && y < lim_y();
	endfunction

	// Per-channel alpha blend, truncated, using the new color's alpha.
	function automatic logic [31:0] blend(logic [31:0] old_px, logic [31:0] col);
		int a;
		int v;
		logic [31:0] mixed;
		a = col[31:24];
		mixed = '0;
		for (int sh = 0; sh < 32; sh += 8) begin
			v = (int'(old_px[sh +: 8]) * (255 - a) + int'(col[sh +: 8]) * a) / 255;
			mixed[sh +: 8] = v[7:0];
		end
		return mixed;
	endfunction

	function automatic void put_pixel(int x, int y, logic [31:0] col);
		int idx;
		if (!on_buffer(x, y)) return;
		idx = y * arlr_pkg::MAX_WIDTH + x;
		pixels[idx] = blend(pixels[idx], col);
	endfunction

	function automatic void draw_column(int x, int ya, int yb, logic [31:0] col);
		if (ya < 0) ya = 0;
		if (yb > lim_y() - 1) yb = lim_y() - 1;
		for (int y = ya; y <= yb; y++) put_pixel(x, y, col);
	endfunction

	function automatic void draw_row(int xa, int xb, int y, logic [31:0] col);
		if (xa < 0) xa = 0;
		if (xb > lim_x() - 1) xb = lim_x() - 1;
		for (int x = xa; x <= xb; x++) put_pixel(x, y, col);
	endfunction

	function automatic void draw_rect(int x1, int y1, int x2, int y2, logic [31:0] col,
		bit filled);
		int t;
		if (x1 > x2) begin
			t = x1; x1 = x2; x2 = t;
		end
		if (y1 > y2) begin
			t = y1; y1 = y2; y2 = t;
		end
		if (x2 < 0 || x1 >= lim_x() || y2 < 0 || y1 >= lim_y()) return;
		if (filled) begin
			for (int y = y1; y <= y2; y++) draw_row(x1, x2, y, col);
		end else begin
			draw_column(x1, y1, y2, col);
			draw_column(x2, y1, y2, col);
			draw_row(x1, x2, y1, col);
			draw_row(x1, x2, y2, col);
		end
	endfunction

	function automatic void draw_line(int x1, int y1, int x2, int y2, logic [31:0] col,
		int w);
		int dx, dy, sx, sy, err, e2, lo, hi;
		dx = (x2 > x1) ? x2 - x1 : x1 - x2;
		dy = (y2 > y1) ? y2 - y1 : y1 - y2;
		sx = (x1 < x2) ? 1 : -1;
		sy = (y1 < y2) ? 1 : -1;
		err = dx - dy;
		lo = -(w / 2);
		hi = (w + 1) / 2;
		forever begin
			for (int ox = lo; ox <= hi; ox++)
				for (int oy = lo; oy <= hi; oy++)
					put_pixel(x1 + ox, y1 + oy, col);
			if (x1 == x2 && y1 == y2) break;
			e2 = 2 * err;
			if (e2 > -dy) begin
				err -= dy;
				x1 += sx;
			end
			if (e2 < dx) begin
				err += dx;
				y1 += sy;
			end
		end
	endfunction

	function automatic result_t run_command(logic [2:0] mode, int xs, int ys, int xe,
		int ye, logic [31:0] col, int w);
		result_t r;
		r.read_color = '0;
		r.done_res = 1'b1;
		case (mode)
			arlr_pkg::MODE_PLOT:    put_pixel(xs, ys, col);
			arlr_pkg::MODE_LINE:    draw_line(xs, ys, xe, ye, col, w);
			arlr_pkg::MODE_OUTLINE: draw_rect(xs, ys, xe, ye, col, 1'b0);
			arlr_pkg::MODE_FILL:    draw_rect(xs, ys, xe, ye, col, 1'b1);
			arlr_pkg::MODE_READ:
				if (on_buffer(xs, ys)) r.read_color = pixels[ys * arlr_pkg::MAX_WIDTH + xs];
			default:      ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < arlr_pkg::DEPTH; i++) pixels[i] = '0;
			clip_w = 7'd64;
			clip_h = 7'd64;
			pending_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == arlr_pkg::REG_WIDTH) clip_w = pwdata[6:0];
				else clip_h = pwdata[6:0];
			end
			if (res.valid && res.ready) begin
				if (pending_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word %h/%b", $time,
						res.read_color, res.done_res);
				end else begin
					want = pending_q.pop_front();
					if (res.read_color !== want.read_color) begin
						errors++;
						$display("%0t: read_color expected %h actual %h", $time,
							want.read_color, res.read_color);
					end
					if (res.done_res !== want.done_res) begin
						errors++;
						$display("%0t: done_res expected %b actual %b", $time,
							want.done_res, res.done_res);
					end
				end
			end
			if (cmd.valid && cmd.ready)
				pending_q.push_back(run_command(cmd.mode, int'(cmd.x_start),
					int'(cmd.y_start), int'(cmd.x_end), int'(cmd.y_end), cmd.color,
					int'(cmd.pen_weight)));
			outstanding = pending_q.size();
		end
	end

endmodule

// File: tb/tb_alpha_blend_line_rect_rasterizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alpha_blend_line_rect_rasterizer_top: drawing engine testbench
// Drives directed and random drawing commands and APB size writes into the
// rasterizer, with random idling on both channels; a checker module beside
// the block predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_alpha_blend_line_rect_rasterizer_top;

	// Longest stretch without any accepted word before the run is declared
	// hung. The slowest legal stretches are the clearing pass after reset and
	// a full-buffer fill or a long clipped line.
	localparam int STALL_LIMIT = 200000;
	localparam int LONG_HOLD   = 400;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          outstanding;
	int          tx_idle;
	int          rx_idle;
	int          hold_ask;
	int          quiet_cycles;

	arlr_cmd_if cmd ();
	arlr_res_if res ();

	alpha_blend_line_rect_rasterizer_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	arlr_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.res         (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver side. Normally ready follows the current idle percentage; each
	// new hold request drops ready for a long stretch so that the result
	// register and the command queue fill up and the block stalls its input.
	initial begin
		int holds_served;
		holds_served = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask != holds_served) begin
				holds_served++;
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				res.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// Watchdog: any accepted word on either channel restarts the count.
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// One command word. Random idle cycles come first, with valid low; after
	// the handshake valid stays high so back-to-back words need no toggle.
	task automatic send_word(logic [2:0] mode, int xs, int ys, int xe, int ye,
		logic [31:0] col, int w);
		while ($urandom_range(99) < tx_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.mode       <= mode;
		cmd.x_start    <= xs[11:0];
		cmd.y_start    <= ys[11:0];
		cmd.x_end      <= xe[11:0];
		cmd.y_end      <= ye[11:0];
		cmd.color      <= col;
		cmd.pen_weight <= w[3:0];
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	// Size registers are only touched once every result word is back; each
	// write is a setup phase followed by an access phase.
	task automatic write_size(logic reg_sel, logic [31:0] value);
		cmd.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Coordinates mostly land on or just around the 64 x 64 store; now and
	// then one spans the whole 12-bit range to reach the sign and high bits.
	function automatic int pick_coord();
		if ($urandom_range(99) < 12) return int'($urandom_range(4095)) - 2048;
		return int'($urandom_range(71)) - 4;
	endfunction

	function automatic logic [31:0] pick_color();
		logic [31:0] c;
		c = $urandom;
		case ($urandom_range(9))
			0, 1: c[31:24] = 8'hff;
			2:    c[31:24] = 8'h00;
			default: ;
		endcase
		return c;
	endfunction

	// Random command. Lines and rectangles are kept short most of the time,
	// since every covered pixel costs the block a read and a write.
	task automatic send_random();
		int pick, xs, ys, xe, ye, w;
		logic [2:0] mode;
		pick = $urandom_range(99);
		xs = pick_coord();
		ys = pick_coord();
		xe = xs + int'($urandom_range(16)) - 8;
		ye = ys + int'($urandom_range(16)) - 8;
		w  = $urandom_range(3);
		if (pick < 25) mode = arlr_pkg::MODE_READ;
		else if (pick < 45) mode = arlr_pkg::MODE_PLOT;
		else if (pick < 70) mode = arlr_pkg::MODE_LINE;
		else if (pick < 84) mode = arlr_pkg::MODE_OUTLINE;
		else if (pick < 96) mode = arlr_pkg::MODE_FILL;
		else mode = 3'($urandom_range(7, 5));
		if (mode == arlr_pkg::MODE_LINE) begin
			case ($urandom_range(29))
				0: begin
					// Long clipped line across the coordinate range, thin pen.
					xe = int'($urandom_range(4095)) - 2048;
					ye = int'($urandom_range(4095)) - 2048;
					w = 0;
				end
				1, 2, 3: begin
					// Heavy pen on a very short line.
					w = $urandom_range(15);
					xe = xs + int'($urandom_range(4)) - 2;
					ye = ys + int'($urandom_range(4)) - 2;
				end
				default: ;
			endcase
		end else if ((mode == arlr_pkg::MODE_OUTLINE || mode == arlr_pkg::MODE_FILL)
			&& $urandom_range(39) == 0) begin
			xe = int'($urandom_range(4095)) - 2048;
			ye = int'($urandom_range(4095)) - 2048;
		end else if (mode != arlr_pkg::MODE_LINE) begin
			w = $urandom_range(15);
			if ($urandom_range(19) == 0) begin
				xe = int'($urandom_range(4095)) - 2048;
				ye = int'($urandom_range(4095)) - 2048;
			end
		end
		send_word(mode, xs, ys, xe, ye, pick_color(), w);
	endtask

	task automatic run_phase(int n_words, int tx_pct, int rx_pct);
		tx_idle = tx_pct;
		rx_idle = rx_pct;
		for (int i = 0; i < n_words; i++) begin
			send_random();
			// Midway, the sender waits for every result to come back.
			if (i == n_words / 2) begin
				cmd.valid <= 1'b0;
				@(posedge clk);
				wait (outstanding == 0);
				@(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.mode = arlr_pkg::MODE_PLOT;
		cmd.x_start = '0;
		cmd.y_start = '0;
		cmd.x_end = '0;
		cmd.y_end = '0;
		cmd.color = '0;
		cmd.pen_weight = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle = 0;
		rx_idle = 0;
		hold_ask = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset size of 64 x 64: corners, clipping at
		// every edge, extreme coordinates and colors, every mode.
		send_word(arlr_pkg::MODE_PLOT, 0, 0, 0, 0, 32'hffffffff, 0);
		send_word(arlr_pkg::MODE_PLOT, 63, 63, 0, 0, 32'h80123456, 15);
		send_word(arlr_pkg::MODE_PLOT, -1, 0, 0, 0, 32'hff00ff00, 0);
		send_word(arlr_pkg::MODE_PLOT, 64, 63, 0, 0, 32'hff00ff00, 0);
		send_word(arlr_pkg::MODE_PLOT, 2047, -2048, -2048, 2047, 32'hffffffff, 0);
		send_word(arlr_pkg::MODE_PLOT, 5, 5, 0, 0, 32'h00abcdef, 0);
		send_word(arlr_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
		send_word(arlr_pkg::MODE_READ, 63, 63, 0, 0, 0, 0);
		send_word(arlr_pkg::MODE_READ, 64, 0, 0, 0, 0, 0);
		send_word(arlr_pkg::MODE_READ, -2048, 2047, 0, 0, 0, 0);
		send_word(arlr_pkg::MODE_LINE, 10, 10, 13, 12, 32'hc0ff8040, 15);
		send_word(arlr_pkg::MODE_LINE, 30, 20, 22, 17, 32'h90204080, 1);
		send_word(arlr_pkg::MODE_LINE, 40, 2, 40, 9, 32'hff0000ff, 2);
		send_word(arlr_pkg::MODE_LINE, -5, 60, 70, 60, 32'h7f7f7f7f, 0);
		send_word(arlr_pkg::MODE_OUTLINE, 20, 30, 12, 25, 32'h80ff0000, 0);
		send_word(arlr_pkg::MODE_OUTLINE, 33, 33, 33, 33, 32'h80ffffff, 0);
		send_word(arlr_pkg::MODE_OUTLINE, -10, -10, 100, 100, 32'h40808080, 0);
		send_word(arlr_pkg::MODE_FILL, 50, 50, 45, 40, 32'h60102030, 0);
		send_word(arlr_pkg::MODE_FILL, 100, 3, 200, 9, 32'hffffffff, 0);
		send_word(arlr_pkg::MODE_FILL, -2048, -2048, 2047, 2047, 32'h20405060, 0);
		send_word(3'd5, 1, 1, 2, 2, 32'hffffffff, 7);
		send_word(3'd6, 1, 1, 2, 2, 32'hffffffff, 7);
		send_word(3'd7, 1, 1, 2, 2, 32'hffffffff, 7);
		send_word(arlr_pkg::MODE_READ, 33, 33, 0, 0, 0, 0);
		send_word(arlr_pkg::MODE_READ, 12, 25, 0, 0, 0, 0);

		// Zero width: nothing lands and every read returns zero. Pixels
		// drawn earlier stay in place for the next setting.
		write_size(arlr_pkg::REG_WIDTH, 32'h0);
		write_size(arlr_pkg::REG_HEIGHT, 32'hffffff85);
		run_phase(40, 0, 0);

		// Oversized sizes clip as the full store. The receiver also takes a
		// long break here while the sender keeps pushing words.
		write_size(arlr_pkg::REG_WIDTH, 32'h7f);
		write_size(arlr_pkg::REG_HEIGHT, 32'h7f);
		hold_ask++;
		run_phase(600, 36, 69);

		write_size(arlr_pkg::REG_WIDTH, 32'd23);
		write_size(arlr_pkg::REG_HEIGHT, 32'd41);
		run_phase(600, 69, 36);

		write_size(arlr_pkg::REG_WIDTH, 32'd64);
		write_size(arlr_pkg::REG_HEIGHT, 32'd1);
		run_phase(300, 0, 0);

		write_size(arlr_pkg::REG_WIDTH, 32'd1);
		write_size(arlr_pkg::REG_HEIGHT, 32'd64);
		hold_ask++;
		run_phase(300, 0, 0);

		cmd.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/arlr_pkg.sv
rtl/core/arlr_if.sv
rtl/core/arlr_front.sv
rtl/core/arlr_back.sv
rtl/core/alpha_blend_line_rect_rasterizer_top.sv
tb/arlr_checker.sv
tb/tb_alpha_blend_line_rect_rasterizer_top.sv
